>>> sv/mlr_pkg.sv
package mlr_pkg;

  // Default coordinate width of the rasterizer.
  localparam int unsigned CoordBitsDef = 12;

  // The decision variable carries three more bits than a coordinate.
  localparam int unsigned DecExtraBits = 3;

  // Depth of the queues between the front and the back and between the back and the output.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);
  localparam int unsigned FifoCntBits = $clog2(FifoDepth + 1);

  // Request codes carried on req_type and in the command word.
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

endpackage

>>> sv/mlr_fifo.sv
module mlr_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0]                   mem_q [mlr_pkg::FifoDepth];
  logic [mlr_pkg::FifoPtrBits-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mlr_pkg::FifoPtrBits-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mlr_pkg::FifoCntBits-1:0]    cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == mlr_pkg::FifoCntBits'(mlr_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == mlr_pkg::FifoPtrBits'(mlr_pkg::FifoDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == mlr_pkg::FifoPtrBits'(mlr_pkg::FifoDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/mlr_front.sv
module mlr_front #(
  parameter int unsigned CoordBits = mlr_pkg::CoordBitsDef,
  localparam int unsigned DecBits = CoordBits + mlr_pkg::DecExtraBits,
  localparam int unsigned CmdWidth = 5 * CoordBits + 7
) (
  input  logic                 req_type_i,
  input  logic [CoordBits-1:0] start_x_i,
  input  logic [CoordBits-1:0] start_y_i,
  input  logic [CoordBits-1:0] end_x_i,
  input  logic [CoordBits-1:0] end_y_i,
  output logic [CmdWidth-1:0]  cmd_o
);

  logic                 x_back, y_back, steep;
  logic [CoordBits-1:0] abs_dx, abs_dy, major, minor;
  logic [DecBits-1:0]   dec_init;
  mlr_pkg::req_e        op;

  // Classify the request and set up the line so the back only iterates.
  always_comb begin
    op       = mlr_pkg::req_e'(req_type_i);
    x_back   = end_x_i < start_x_i;
    y_back   = end_y_i < start_y_i;
    abs_dx   = x_back ? start_x_i - end_x_i : end_x_i - start_x_i;
    abs_dy   = y_back ? start_y_i - end_y_i : end_y_i - start_y_i;
    steep    = abs_dy >= abs_dx;
    major    = steep ? abs_dy : abs_dx;
    minor    = steep ? abs_dx : abs_dy;
    dec_init = (DecBits'(minor) << 1) - DecBits'(major);
  end

  assign cmd_o = {op, start_x_i, start_y_i, abs_dx, abs_dy, x_back, y_back, steep, dec_init};

endmodule

>>> sv/mlr_back.sv
module mlr_back #(
  parameter int unsigned CoordBits = mlr_pkg::CoordBitsDef,
  localparam int unsigned DecBits = CoordBits + mlr_pkg::DecExtraBits,
  localparam int unsigned CmdWidth = 5 * CoordBits + 7,
  localparam int unsigned ResWidth = 2 * CoordBits + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  logic [CmdWidth-1:0] cmd_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output logic [ResWidth-1:0] res_o
);

  // Unpacked command.
  logic                 c_req;
  mlr_pkg::req_e        c_op;
  logic [CoordBits-1:0] c_sx, c_sy, c_adx, c_ady;
  logic                 c_xb, c_yb, c_steep;
  logic [DecBits-1:0]   c_dec;
  logic [CoordBits-1:0] c_major;

  // Line state.
  logic [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordBits-1:0] adx_q, adx_d, ady_q, ady_d;
  logic [CoordBits-1:0] steps_q, steps_d;
  logic [DecBits-1:0]   dec_q, dec_d;
  logic                 xb_q, xb_d, yb_q, yb_d, steep_q, steep_d, busy_q, busy_d;

  logic                 fire, diag;
  logic [CoordBits-1:0] major, minor, step_x, step_y, steps_dec;
  logic [DecBits-1:0]   inc;
  logic                 r_valid, r_last;
  logic [CoordBits-1:0] r_x, r_y;

  assign {c_req, c_sx, c_sy, c_adx, c_ady, c_xb, c_yb, c_steep, c_dec} = cmd_i;
  assign c_op    = mlr_pkg::req_e'(c_req);
  assign c_major = c_steep ? c_ady : c_adx;

  assign fire       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign res_o      = {r_valid, r_x, r_y, r_last};

  // One midpoint step on the registered state.
  always_comb begin
    major     = steep_q ? ady_q : adx_q;
    minor     = steep_q ? adx_q : ady_q;
    diag      = !dec_q[DecBits-1];
    inc       = diag ? (DecBits'(minor) - DecBits'(major)) << 1
                     : DecBits'(minor) << 1;
    step_x    = cur_x_q;
    step_y    = cur_y_q;
    if (!steep_q || diag) begin
      step_x = xb_q ? cur_x_q - CoordBits'(1) : cur_x_q + CoordBits'(1);
    end
    if (steep_q || diag) begin
      step_y = yb_q ? cur_y_q - CoordBits'(1) : cur_y_q + CoordBits'(1);
    end
    steps_dec = steps_q - CoordBits'(1);
  end

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    steps_d = steps_q;
    dec_d   = dec_q;
    xb_d    = xb_q;
    yb_d    = yb_q;
    steep_d = steep_q;
    busy_d  = busy_q;
    r_valid = 1'b0;
    r_x     = '0;
    r_y     = '0;
    r_last  = 1'b0;
    unique case (c_op)
      mlr_pkg::REQ_LOAD: begin
        cur_x_d = c_sx;
        cur_y_d = c_sy;
        adx_d   = c_adx;
        ady_d   = c_ady;
        xb_d    = c_xb;
        yb_d    = c_yb;
        steep_d = c_steep;
        dec_d   = c_dec;
        steps_d = c_major;
        busy_d  = (c_major != '0);
        r_valid = 1'b1;
        r_x     = c_sx;
        r_y     = c_sy;
        r_last  = (c_major == '0);
      end
      mlr_pkg::REQ_STEP: begin
        if (busy_q) begin
          cur_x_d = step_x;
          cur_y_d = step_y;
          dec_d   = dec_q + inc;
          steps_d = steps_dec;
          busy_d  = (steps_dec != '0);
          r_valid = 1'b1;
          r_x     = step_x;
          r_y     = step_y;
          r_last  = (steps_dec == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      adx_q   <= '0;
      ady_q   <= '0;
      steps_q <= '0;
      dec_q   <= '0;
      xb_q    <= 1'b0;
      yb_q    <= 1'b0;
      steep_q <= 1'b0;
      busy_q  <= 1'b0;
    end else if (fire) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      steps_q <= steps_d;
      dec_q   <= dec_d;
      xb_q    <= xb_d;
      yb_q    <= yb_d;
      steep_q <= steep_d;
      busy_q  <= busy_d;
    end
  end

endmodule

>>> sv/midpoint_line_rasterizer_core.sv
// Channel   | Direction | Handshake          | Fields
// ----------+-----------+--------------------+----------------------------------------
// request   | in        | push / full        | req_type, start_x, start_y, end_x, end_y
// pixel     | out       | pop / empty        | pixel_valid, pixel_x, pixel_y, last_pixel
//
// Every request yields exactly one pixel item, and one item can be taken per cycle.
// An accepted item is written into the command queue; the back then runs one midpoint
// step on it, once the pixel queue has room, and writes the pixel queue, whose head
// drives the pixel outputs.
// Reset clears both queues and leaves the line state idle with all coordinates zero.
// A stalled pixel output fills the pixel queue, then the command queue, and only
// then raises full; each side keeps moving while the other waits.
module midpoint_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  req_type_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  pop,
  output logic                  empty,
  output logic                  pixel_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);

  localparam int unsigned CmdWidth = 5 * COORD_BITS + 7;
  localparam int unsigned ResWidth = 2 * COORD_BITS + 2;

  // The front classifies each request and, for a load, works out the
  // directions, the magnitudes, the steep choice and the first decision value.
  logic [CmdWidth-1:0] front_cmd;
  logic [CmdWidth-1:0] cmd_head;
  logic                cmd_empty, cmd_pop;
  logic [ResWidth-1:0] res_word, res_head;
  logic                res_full, res_push;

  mlr_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .req_type_i(req_type_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .cmd_o     (front_cmd)
  );

  // The command queue decouples request intake from line stepping.
  mlr_fifo #(
    .Width(CmdWidth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  // The back holds the line state and executes one command whenever the command
  // queue holds one and the pixel queue has room.
  mlr_back #(
    .CoordBits(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_word)
  );

  // The pixel queue holds finished items until the consumer pops them.
  mlr_fifo #(
    .Width(ResWidth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_word),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head),
    .empty_o(empty)
  );

  assign {pixel_valid_o, pixel_x_o, pixel_y_o, last_pixel_o} = res_head;

endmodule
